### rtl/core/qpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_pkg
// Shared widths, constants and the lane type of the normalized quaternion
// product pipeline.
// ----------------------------------------------------------------------------
package qpn_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int IN_W      = 8 * DW;
  localparam int OUT_W     = 4 * DW;
  localparam int PW        = 2 * DW;
  localparam int CW        = PW + 2;
  localparam int MW        = 32;
  localparam int SW        = 64;
  localparam int RW        = SW / 2;
  localparam int REMW      = RW + 3;
  localparam int QW        = FRAC_BITS + 2;
  localparam int NW        = RW + FRAC_BITS + 2;
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = RW / SQ_STEPS;
  localparam int DV_STEPS  = 4;
  localparam int DV_STAGES = (QW + DV_STEPS - 1) / DV_STEPS;

  localparam int UNIT_MAG  = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);

  typedef struct packed {
    logic               zero;
    logic [3:0]         neg;
    logic [3:0][MW-1:0] mag;
  } lane_t;

endpackage

### rtl/core/qpn_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_prod
// Hamilton product, component magnitudes, squares and the squared norm,
// five register stages.
// ----------------------------------------------------------------------------
module qpn_prod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qpn_pkg::IN_W-1:0]  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [qpn_pkg::SW-1:0]    out_s,
  output qpn_pkg::lane_t            out_lane
);

  localparam int NST = 5;

  logic [NST-1:0] v;
  logic [NST-1:0] ld;

  logic signed [qpn_pkg::DW-1:0] a [0:3];
  logic signed [qpn_pkg::DW-1:0] b [0:3];
  logic                          allmin;

  logic signed [qpn_pkg::PW-1:0] pr [0:3][0:3];
  logic                          allmin1;
  logic signed [qpn_pkg::CW-1:0] c [0:3];
  logic                          allmin2;
  logic signed [qpn_pkg::CW-1:0] cabs [0:3];
  qpn_pkg::lane_t                lane3_next;
  qpn_pkg::lane_t                lane3;
  logic [qpn_pkg::SW-1:0]        sq [0:3];
  qpn_pkg::lane_t                lane4;
  logic [qpn_pkg::SW-1:0]        s5;
  qpn_pkg::lane_t                lane5;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = in_data[qpn_pkg::DW*i +: qpn_pkg::DW];
      b[i] = in_data[qpn_pkg::DW*(i+4) +: qpn_pkg::DW];
    end
  end

  // only an all most-negative input overflows the norm sum
  assign allmin = (in_data == {8{1'b1, {(qpn_pkg::DW-1){1'b0}}}});

  always_comb begin
    ld[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST-2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) v[i] <= v[i-1];
      end
    end
  end

  always_comb begin
    lane3_next      = '0;
    lane3_next.zero = 1'b0;
    for (int i = 0; i < 4; i++) begin
      lane3_next.neg[i] = c[i][qpn_pkg::CW-1];
      cabs[i] = c[i][qpn_pkg::CW-1] ? -c[i] : c[i];
      lane3_next.mag[i] = allmin2 ? cabs[i][qpn_pkg::MW:1] : cabs[i][qpn_pkg::MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr[i][j] <= qpn_pkg::PW'(a[i] * b[j]);
        end
      end
      allmin1 <= allmin;
    end
    if (ld[1]) begin
      c[0] <= qpn_pkg::CW'(pr[0][0]) - qpn_pkg::CW'(pr[1][1])
            - qpn_pkg::CW'(pr[2][2]) - qpn_pkg::CW'(pr[3][3]);
      c[1] <= qpn_pkg::CW'(pr[0][1]) + qpn_pkg::CW'(pr[1][0])
            + qpn_pkg::CW'(pr[2][3]) - qpn_pkg::CW'(pr[3][2]);
      c[2] <= qpn_pkg::CW'(pr[0][2]) - qpn_pkg::CW'(pr[1][3])
            + qpn_pkg::CW'(pr[2][0]) + qpn_pkg::CW'(pr[3][1]);
      c[3] <= qpn_pkg::CW'(pr[0][3]) + qpn_pkg::CW'(pr[1][2])
            - qpn_pkg::CW'(pr[2][1]) + qpn_pkg::CW'(pr[3][0]);
      allmin2 <= allmin1;
    end
    if (ld[2]) begin
      lane3 <= lane3_next;
    end
    if (ld[3]) begin
      for (int i = 0; i < 4; i++) begin
        sq[i] <= qpn_pkg::SW'(lane3.mag[i]) * qpn_pkg::SW'(lane3.mag[i]);
      end
      lane4 <= lane3;
    end
    if (ld[4]) begin
      s5    <= sq[0] + sq[1] + sq[2] + sq[3];
      lane5 <= lane4;
    end
  end

  assign out_valid = v[NST-1];
  assign out_s     = s5;
  assign out_lane  = lane5;

endmodule

### rtl/core/qpn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_norm
// Leading-pair normalization of the squared norm, with the matching shift
// of the component magnitudes, two register stages.
// ----------------------------------------------------------------------------
module qpn_norm (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [qpn_pkg::SW-1:0]  in_s,
  input  qpn_pkg::lane_t          in_lane,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [qpn_pkg::SW-1:0]  out_s,
  output qpn_pkg::lane_t          out_lane
);

  logic [1:0] v;
  logic [1:0] ld;

  logic [qpn_pkg::SW-1:0] sa_next;
  qpn_pkg::lane_t         la_next;
  logic [qpn_pkg::SW-1:0] sa;
  qpn_pkg::lane_t         la;
  logic [qpn_pkg::SW-1:0] sb_next;
  qpn_pkg::lane_t         lb_next;
  logic [qpn_pkg::SW-1:0] sb;
  qpn_pkg::lane_t         lb;

  assign ld[1]    = !v[1] || out_ready;
  assign ld[0]    = !v[0] || ld[1];
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      if (ld[1]) v[1] <= v[0];
    end
  end

  always_comb begin
    sa_next      = in_s;
    la_next      = in_lane;
    la_next.zero = (in_s == '0);
    if (sa_next[63:32] == '0) begin
      sa_next = sa_next << 32;
      for (int i = 0; i < 4; i++) la_next.mag[i] = la_next.mag[i] << 16;
    end
    if (sa_next[63:48] == '0) begin
      sa_next = sa_next << 16;
      for (int i = 0; i < 4; i++) la_next.mag[i] = la_next.mag[i] << 8;
    end
  end

  always_comb begin
    sb_next = sa;
    lb_next = la;
    if (sb_next[63:56] == '0) begin
      sb_next = sb_next << 8;
      for (int i = 0; i < 4; i++) lb_next.mag[i] = lb_next.mag[i] << 4;
    end
    if (sb_next[63:60] == '0) begin
      sb_next = sb_next << 4;
      for (int i = 0; i < 4; i++) lb_next.mag[i] = lb_next.mag[i] << 2;
    end
    if (sb_next[63:62] == '0) begin
      sb_next = sb_next << 2;
      for (int i = 0; i < 4; i++) lb_next.mag[i] = lb_next.mag[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sa <= sa_next;
      la <= la_next;
    end
    if (ld[1]) begin
      sb <= sb_next;
      lb <= lb_next;
    end
  end

  assign out_valid = v[1];
  assign out_s     = sb;
  assign out_lane  = lb;

endmodule

### rtl/core/qpn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_sqrt
// Pipelined digit-by-digit integer square root of the normalized norm,
// four result bits per stage.
// ----------------------------------------------------------------------------
module qpn_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [qpn_pkg::SW-1:0]  in_s,
  input  qpn_pkg::lane_t          in_lane,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [qpn_pkg::RW-1:0]  out_root,
  output qpn_pkg::lane_t          out_lane
);

  localparam int NST = qpn_pkg::SQ_STAGES;

  logic [NST-1:0] v;
  logic [NST-1:0] ld;

  logic [qpn_pkg::REMW-1:0] rem  [0:NST-1];
  logic [qpn_pkg::RW-1:0]   root [0:NST-1];
  logic [qpn_pkg::SW-1:0]   sv   [0:NST-1];
  qpn_pkg::lane_t           lane [0:NST-1];

  always_comb begin
    ld[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST-2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) v[i] <= v[i-1];
      end
    end
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [qpn_pkg::REMW-1:0] rin;
    logic [qpn_pkg::RW-1:0]   qin;
    logic [qpn_pkg::SW-1:0]   sin;
    qpn_pkg::lane_t           lin;
    logic [qpn_pkg::REMW-1:0] r;
    logic [qpn_pkg::REMW-1:0] r2;
    logic [qpn_pkg::REMW-1:0] tr;
    logic [qpn_pkg::RW-1:0]   q;
    logic [qpn_pkg::SW-1:0]   s;

    if (g == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign sin = in_s;
      assign lin = in_lane;
    end else begin : g_next
      assign rin = rem[g-1];
      assign qin = root[g-1];
      assign sin = sv[g-1];
      assign lin = lane[g-1];
    end

    always_comb begin
      r = rin;
      q = qin;
      s = sin;
      r2 = '0;
      tr = '0;
      for (int t = 0; t < qpn_pkg::SQ_STEPS; t++) begin
        r2 = {r[qpn_pkg::REMW-3:0], s[qpn_pkg::SW-1 -: 2]};
        tr = qpn_pkg::REMW'({q, 2'b01});
        if (r2 >= tr) begin
          r = r2 - tr;
          q = {q[qpn_pkg::RW-2:0], 1'b1};
        end else begin
          r = r2;
          q = {q[qpn_pkg::RW-2:0], 1'b0};
        end
        s = s << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[g]) begin
        rem[g]  <= r;
        root[g] <= q;
        sv[g]   <= s;
        lane[g] <= lin;
      end
    end
  end

  assign out_valid = v[NST-1];
  assign out_root  = root[NST-1];
  assign out_lane  = lane[NST-1];

endmodule

### rtl/core/qpn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_div
// Four-lane pipelined restoring divider giving the rounded unit components,
// then clamp, sign and the zero-norm identity in the output register.
// ----------------------------------------------------------------------------
module qpn_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [qpn_pkg::RW-1:0]   in_root,
  input  qpn_pkg::lane_t           in_lane,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [qpn_pkg::OUT_W-1:0] out_data,
  output logic                     out_zero
);

  localparam int NST = qpn_pkg::DV_STAGES + 1;
  localparam int DVS = qpn_pkg::DV_STAGES;
  localparam logic [qpn_pkg::QW-1:0] LIM = qpn_pkg::QW'(qpn_pkg::UNIT_MAG);

  logic [NST-1:0] v;
  logic [NST-1:0] ld;

  logic [3:0][qpn_pkg::NW-1:0] rem  [0:DVS-1];
  logic [3:0][qpn_pkg::QW-1:0] quo  [0:DVS-1];
  logic [qpn_pkg::RW:0]        dv   [0:DVS-1];
  logic [3:0]                  neg  [0:DVS-1];
  logic                        zero [0:DVS-1];

  logic [qpn_pkg::OUT_W-1:0]   data_next;
  logic [qpn_pkg::OUT_W-1:0]   data;
  logic                        zflag;
  logic [qpn_pkg::QW-1:0]      qs;
  logic [qpn_pkg::QW-1:0]      qv;

  always_comb begin
    ld[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST-2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) v[i] <= v[i-1];
      end
    end
  end

  for (genvar g = 0; g < DVS; g++) begin : g_st
    logic [3:0][qpn_pkg::NW-1:0] rin;
    logic [3:0][qpn_pkg::QW-1:0] qin;
    logic [qpn_pkg::RW:0]        din;
    logic [3:0]                  nin;
    logic                        zin;
    logic [3:0][qpn_pkg::NW-1:0] r;
    logic [3:0][qpn_pkg::QW-1:0] q;
    logic [qpn_pkg::NW-1:0]      dsh;

    if (g == 0) begin : g_first
      // numerator carries the half-divisor term for round to nearest
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          rin[i] = (qpn_pkg::NW'(in_lane.mag[i]) << (qpn_pkg::FRAC_BITS + 1))
                 + qpn_pkg::NW'(in_root);
        end
      end
      assign qin = '0;
      assign din = {in_root, 1'b0};
      assign nin = in_lane.neg;
      assign zin = in_lane.zero;
    end else begin : g_next
      assign rin = rem[g-1];
      assign qin = quo[g-1];
      assign din = dv[g-1];
      assign nin = neg[g-1];
      assign zin = zero[g-1];
    end

    always_comb begin
      r   = rin;
      q   = qin;
      dsh = '0;
      for (int t = 0; t < qpn_pkg::DV_STEPS; t++) begin
        if (qpn_pkg::QW - 1 - (g * qpn_pkg::DV_STEPS + t) >= 0) begin
          dsh = qpn_pkg::NW'(din) << (qpn_pkg::QW - 1 - (g * qpn_pkg::DV_STEPS + t));
          for (int i = 0; i < 4; i++) begin
            if (r[i] >= dsh) begin
              r[i] = r[i] - dsh;
              q[i] = {q[i][qpn_pkg::QW-2:0], 1'b1};
            end else begin
              q[i] = {q[i][qpn_pkg::QW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[g]) begin
        rem[g]  <= r;
        quo[g]  <= q;
        dv[g]   <= din;
        neg[g]  <= nin;
        zero[g] <= zin;
      end
    end
  end

  always_comb begin
    data_next = '0;
    qs = '0;
    qv = '0;
    for (int i = 0; i < 4; i++) begin
      qs = (quo[DVS-1][i] > LIM) ? LIM : quo[DVS-1][i];
      qv = neg[DVS-1][i] ? -qs : qs;
      data_next[qpn_pkg::DW*i +: qpn_pkg::DW] = qv[qpn_pkg::DW-1:0];
    end
    if (zero[DVS-1]) begin
      data_next = qpn_pkg::OUT_W'(LIM[qpn_pkg::DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NST-1]) begin
      data  <= data_next;
      zflag <= zero[DVS-1];
    end
  end

  assign out_valid = v[NST-1];
  assign out_data  = data;
  assign out_zero  = zflag;

endmodule

### rtl/core/quaternion_product_normalize_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_normalize_top
// Normalized Hamilton product of two Q1.14 quaternions.
//
// Input stream s_*: one word holds both quaternions a and b. Output stream
// m_*: one word holds the unit product, tuser flags a zero-norm product, for
// which the identity (1,0,0,0) is returned.
// From input accept to m_tvalid a word passes five stages for products,
// sums, magnitudes, squares and the norm sum, two for the normalizing
// shift, eight for the square root at four bits a stage, four for the
// divider at four quotient bits a stage and one output register.
// Throughput is one word per cycle while m_tready is high (fully pipelined).
// Each stage has its own valid bit, so bubbles close up and s_tready stays
// high while any stage is free, also while an output word waits.
// When m_tready is low the output word holds and the stages behind it fill.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_product_normalize_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [qpn_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // p_w, p_x, p_y, p_z
  output logic [qpn_pkg::OUT_W-1:0]  m_tdata,
  // zero_norm
  output logic [0:0]                 m_tuser
);

  logic                    p_valid;
  logic                    p_ready;
  logic [qpn_pkg::SW-1:0]  p_s;
  qpn_pkg::lane_t          p_lane;
  logic                    n_valid;
  logic                    n_ready;
  logic [qpn_pkg::SW-1:0]  n_s;
  qpn_pkg::lane_t          n_lane;
  logic                    r_valid;
  logic                    r_ready;
  logic [qpn_pkg::RW-1:0]  r_root;
  qpn_pkg::lane_t          r_lane;

  qpn_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_s     (p_s),
    .out_lane  (p_lane)
  );

  qpn_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_s      (p_s),
    .in_lane   (p_lane),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_s     (n_s),
    .out_lane  (n_lane)
  );

  qpn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_s      (n_s),
    .in_lane   (n_lane),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_root  (r_root),
    .out_lane  (r_lane)
  );

  qpn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_root   (r_root),
    .in_lane   (r_lane),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_zero  (m_tuser[0])
  );

endmodule

### rtl/core/qpn_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpn_check
// Port-level checks of the normalized quaternion product block, bound to
// the top level.
// ----------------------------------------------------------------------------
module qpn_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [qpn_pkg::IN_W-1:0]   s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [qpn_pkg::OUT_W-1:0]  m_tdata,
  input logic [0:0]                 m_tuser
);

  localparam logic signed [qpn_pkg::DW-1:0] LIM = qpn_pkg::DW'(qpn_pkg::UNIT_MAG);

  logic signed [qpn_pkg::DW-1:0] pw;
  logic signed [qpn_pkg::DW-1:0] px;
  logic signed [qpn_pkg::DW-1:0] py;
  logic signed [qpn_pkg::DW-1:0] pz;

  assign pw = m_tdata[qpn_pkg::DW*0 +: qpn_pkg::DW];
  assign px = m_tdata[qpn_pkg::DW*1 +: qpn_pkg::DW];
  assign py = m_tdata[qpn_pkg::DW*2 +: qpn_pkg::DW];
  assign pz = m_tdata[qpn_pkg::DW*3 +: qpn_pkg::DW];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> pw == LIM && px == '0 && py == '0 && pz == '0)
    else $error("zero-norm word is not the identity");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      pw <= LIM && pw >= -LIM && px <= LIM && px >= -LIM &&
      py <= LIM && py >= -LIM && pz <= LIM && pz >= -LIM)
    else $error("unit component out of range");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata != '0)
    else $error("unit quaternion with all components zero");

endmodule

bind quaternion_product_normalize_top qpn_check u_qpn_check (.*);
